[rtl/core/fftr_pkg.sv]
// shared constants and types of the fixed-frame target receiver
`timescale 1ns / 1ps

package fftr_pkg;

	localparam logic [7:0] HEADER_BYTE  = 8'h5C;
	localparam logic [7:0] TRAILER_BYTE = 8'hED;

	// frame bytes seen so far, header included; zero means no frame open
	localparam int          COUNT_W     = 4;
	localparam logic [3:0]  TRAILER_POS = 4'd13;

	localparam int PAYLOAD_LEN  = 12;
	localparam int PAYLOAD_BITS = PAYLOAD_LEN * 8;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_END = 1'b1;

	typedef struct packed {
		logic               frame_status;
		logic signed [31:0] target_color;
		logic signed [31:0] pixel_x;
		logic signed [31:0] pixel_y;
	} target_res_t;

endpackage

[rtl/core/fftr_if.sv]
// valid/ready channels: received byte items in, decoded target items out
`timescale 1ns / 1ps

interface fftr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fftr_res_if;
	logic               valid;
	logic               ready;
	logic               frame_status;
	logic signed [31:0] target_color;
	logic signed [31:0] pixel_x;
	logic signed [31:0] pixel_y;

	modport source (output valid, output frame_status, output target_color,
		output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input frame_status, input target_color,
		input pixel_x, input pixel_y, output ready);
endinterface

[rtl/core/fftr_parse.sv]
// input register, frame counter, payload shift line and result decode
`timescale 1ns / 1ps

module fftr_parse import fftr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	output logic        in_ready,
	input  logic        buf_full,
	output logic        res_push,
	output target_res_t res
);

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic [COUNT_W-1:0]       count_q;
	logic [PAYLOAD_BITS-1:0]  payload_q;
	logic                     advance;
	logic                     at_trailer;

	assign advance    = valid_s1 && !buf_full;
	assign in_ready   = !valid_s1 || !buf_full;
	// counts of 14 and 15 cannot occur but close the frame like the trailer
	assign at_trailer = (count_q >= TRAILER_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				if (count_q == '0) begin
					if (byte_s1 == HEADER_BYTE) begin
						count_q <= COUNT_W'(1);
					end
				end else if (!at_trailer) begin
					count_q <= count_q + COUNT_W'(1);
				end else begin
					count_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= in_byte;
		end
		// payload bytes shift in, first byte ends up in the top byte
		if (advance && count_q != '0 && !at_trailer) begin
			payload_q <= {payload_q[PAYLOAD_BITS-9:0], byte_s1};
		end
	end

	always_comb begin
		res_push = advance && at_trailer;
		if (byte_s1 == TRAILER_BYTE) begin
			res.frame_status = STATUS_OK;
			res.target_color = payload_q[95:64];
			res.pixel_x      = payload_q[63:32];
			res.pixel_y      = payload_q[31:0];
		end else begin
			res.frame_status = STATUS_BAD_END;
			res.target_color = '0;
			res.pixel_x      = '0;
			res.pixel_y      = '0;
		end
	end

endmodule

[rtl/core/fftr_out_buf.sv]
// two-entry result queue that decouples the decoder from the output side
`timescale 1ns / 1ps

module fftr_out_buf import fftr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  target_res_t push_data,
	output logic        full,
	output logic        out_valid,
	input  logic        out_ready,
	output target_res_t out_data
);

	target_res_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (fill_q != 2'd0);
	assign full      = (fill_q == 2'd2);
	assign out_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/core/fixed_frame_target_receiver_unit.sv]
// top level of the fixed-frame target receiver
`timescale 1ns / 1ps

//  port    | role | payload                                         | item
//  --------+------+-------------------------------------------------+------------------------
//  rx      | sink | rx_byte                                         | one received serial byte
//  target  | src  | frame_status, target_color, pixel_x, pixel_y    | one decoded frame
//
//  one byte item is taken per cycle unless a byte waits in the input register and the
//  result queue is full; its result, if any, passes the input register, then the result queue
//  a frame of 14 bytes gives exactly one result item
//  arst_n clears the frame counter, the input valid and the result queue
//  a stalled target side fills the two-entry queue, then rx ready drops

module fixed_frame_target_receiver_unit import fftr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fftr_rx_if.sink    rx,
	fftr_res_if.source target
);

	logic        buf_full;
	logic        res_push;
	target_res_t res;
	target_res_t out_res;

	// header hunt, payload capture and trailer check
	fftr_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_byte  (rx.rx_byte),
		.in_ready (rx.ready),
		.buf_full (buf_full),
		.res_push (res_push),
		.res      (res)
	);

	// result queue keeps input flowing while a result waits
	fftr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.full      (buf_full),
		.out_valid (target.valid),
		.out_ready (target.ready),
		.out_data  (out_res)
	);

	assign target.frame_status = out_res.frame_status;
	assign target.target_color = out_res.target_color;
	assign target.pixel_x      = out_res.pixel_x;
	assign target.pixel_y      = out_res.pixel_y;

endmodule

[dv/tb_fixed_frame_target_receiver_unit.sv]
// self-checking testbench of the fixed-frame target receiver: byte stream in, decoded targets out
`timescale 1ns / 1ps

module tb_fixed_frame_target_receiver_unit;
	import fftr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	fftr_rx_if  rx_ch ();
	fftr_res_if res_ch ();

	fixed_frame_target_receiver_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.target (res_ch)
	);

	// predictor state: open frame position and the payload collected so far
	logic [3:0]  frame_pos;
	logic [7:0]  frame_payload [PAYLOAD_LEN];
	target_res_t pending_targets [$];

	int  mismatches;
	int  frame_items;
	int  cycles;
	int  hold_req;
	bit  src_idle_en;
	bit  sink_idle_en;

	always #4 clk = ~clk;

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		rx_ch.valid     = 1'b0;
		rx_ch.rx_byte   = 8'h00;
		res_ch.ready    = 1'b0;
		frame_pos       = '0;
		mismatches      = 0;
		frame_items     = 0;
		cycles          = 0;
		hold_req        = 0;
		src_idle_en     = 1'b0;
		sink_idle_en    = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// idle length: mostly short, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// advance the frame model by one accepted byte, queue a target when a frame closes
	function automatic void predict_target(logic [7:0] b);
		target_res_t r;
		if (frame_pos == 0) begin
			if (b == HEADER_BYTE)
				frame_pos = 4'd1;
		end else if (frame_pos < TRAILER_POS) begin
			frame_payload[frame_pos - 1] = b;
			frame_pos = frame_pos + 4'd1;
		end else begin
			// trailer position closes the frame whatever the byte is
			frame_pos = '0;
			if (b != TRAILER_BYTE) begin
				r.frame_status = STATUS_BAD_END;
				r.target_color = '0;
				r.pixel_x      = '0;
				r.pixel_y      = '0;
			end else begin
				r.frame_status = STATUS_OK;
				r.target_color = {frame_payload[0], frame_payload[1],
					frame_payload[2], frame_payload[3]};
				r.pixel_x      = {frame_payload[4], frame_payload[5],
					frame_payload[6], frame_payload[7]};
				r.pixel_y      = {frame_payload[8], frame_payload[9],
					frame_payload[10], frame_payload[11]};
			end
			pending_targets.push_back(r);
		end
	endfunction

	// offer one byte item, optionally after an idle gap, and wait for acceptance
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (src_idle_en && $urandom_range(0, 2) == 0) begin
			gap = idle_len();
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		predict_target(b);
	endtask

	// header, twelve big-endian payload bytes, then the given trailer
	task automatic send_frame(input logic [31:0] color, input logic [31:0] x,
		input logic [31:0] y, input logic [7:0] trailer);
		logic [95:0] words;
		words = {color, x, y};
		send_byte(HEADER_BYTE);
		for (int i = 0; i < PAYLOAD_LEN; i++)
			send_byte(words[95 - 8 * i -: 8]);
		send_byte(trailer);
		frame_items += 14;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [7:0] bad_trailer();
		logic [7:0] t;
		if ($urandom_range(0, 1) == 0)
			return HEADER_BYTE;
		t = 8'($urandom_range(0, 255));
		while (t == TRAILER_BYTE)
			t = 8'($urandom_range(0, 255));
		return t;
	endfunction

	// sender goes quiet, then waits for every predicted target
	task automatic wait_targets_drained();
		rx_ch.valid <= 1'b0;
		while (pending_targets.size() != 0) @(posedge clk);
	endtask

	// target side: random stalls, plus a long hold-off when a test asks for one
	initial begin : target_sink
		int stall;
		stall = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				stall    = hold_req;
				hold_req = 0;
			end else if (stall == 0 && sink_idle_en && $urandom_range(0, 3) == 0) begin
				stall = idle_len();
			end
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: target %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// compare every accepted target item with the oldest prediction
	always @(posedge clk) begin : target_check
		target_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_targets.size() == 0) begin
				$display("%0t: unexpected target item, expected none, actual %b %h %h %h",
					$time, res_ch.frame_status, res_ch.target_color, res_ch.pixel_x,
					res_ch.pixel_y);
				mismatches++;
			end else begin
				want = pending_targets.pop_front();
				check_field("frame_status", {31'd0, want.frame_status},
					{31'd0, res_ch.frame_status});
				check_field("target_color", want.target_color, res_ch.target_color);
				check_field("pixel_x", want.pixel_x, res_ch.pixel_x);
				check_field("pixel_y", want.pixel_y, res_ch.pixel_y);
			end
		end
	end

	// extremes of each word, header and trailer values inside the payload,
	// noise before a header, and a bad trailer that must not reopen a frame
	task automatic test_directed_frames();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(TRAILER_BYTE);
		send_frame(32'h8000_0000, 32'h7FFF_FFFF, {HEADER_BYTE, TRAILER_BYTE, 16'h00FF},
			TRAILER_BYTE);
		send_frame(32'hFFFF_FFFF, 32'h0000_0000, 32'h5C5C_EDED, HEADER_BYTE);
		send_byte(8'h01);
		send_frame(32'h0000_0001, 32'hFFFF_FFFE, 32'h1234_5678, 8'hEC);
	endtask

	// mostly well-formed frames with random content, some bad trailers and noise
	task automatic test_random_stream(input int n_items);
		int start;
		int k;
		int n_noise;
		start = frame_items;
		while (frame_items - start < n_items) begin
			if ($urandom_range(0, 7) == 0) src_idle_en = !src_idle_en;
			if ($urandom_range(0, 7) == 0) sink_idle_en = !sink_idle_en;
			k = $urandom_range(0, 9);
			if (k < 7) begin
				send_frame(rand_word(), rand_word(), rand_word(), TRAILER_BYTE);
			end else if (k < 8) begin
				send_frame(rand_word(), rand_word(), rand_word(), bad_trailer());
			end else begin
				// stray bytes; a header among them opens a frame of random bytes
				n_noise = $urandom_range(1, 5);
				for (int i = 0; i < n_noise; i++)
					send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// target side held off while frames keep coming, so the result queue fills
	// and byte acceptance stalls
	task automatic test_output_backpressure();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		hold_req     = 250;
		for (int i = 0; i < 6; i++)
			send_frame(rand_word(), rand_word(), rand_word(),
				(i == 3) ? bad_trailer() : TRAILER_BYTE);
	endtask

	// sender stops until every predicted target has arrived, then resumes
	task automatic test_sender_pause();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		send_frame(rand_word(), rand_word(), rand_word(), TRAILER_BYTE);
		send_frame(rand_word(), rand_word(), rand_word(), TRAILER_BYTE);
		wait_targets_drained();
		send_byte(8'hA5);
		send_frame(rand_word(), rand_word(), rand_word(), bad_trailer());
		wait_targets_drained();
		send_frame(rand_word(), rand_word(), rand_word(), TRAILER_BYTE);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_random_stream(480);
		test_output_backpressure();
		test_sender_pause();
		test_random_stream(60);

		wait_targets_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_targets.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
